@@ design/rope_pkg.sv @@
`default_nettype none

package rope_pkg;

    // Field widths
    localparam int SAMPLE_W    = 16;
    localparam int POS_W       = 16;
    localparam int PAIR_IDX_W  = 6;
    localparam int PAIR_COUNT  = 64;

    // Frequency table build constants
    localparam int HEAD_LEN    = 128;
    localparam int ROPE_BASE   = 10000;
    localparam int LOG_FRAC    = 40;
    localparam int FREQ_FRAC   = 44;
    localparam int PHASE_W     = 32;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 28;
    localparam int GUARD_BITS   = 16;
    localparam int XW           = 36;   // x/y working width, holds gain growth
    localparam int ZW           = 34;   // residual angle width, 2^-32 turn units

    localparam logic signed [31:0] INV_GAIN_Q30   = 32'sd652032874;
    localparam logic [63:0]        INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic [63:0]        LN2_Q64        = 64'hB17217F7D1CF79AC;

    // Channel payloads
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] first_value;
        logic signed [SAMPLE_W-1:0] second_value;
        logic [PAIR_IDX_W-1:0]      pair_index;
        logic [POS_W-1:0]           token_offset;
    } t_rope_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] rotated_first;
        logic signed [SAMPLE_W-1:0] rotated_second;
    } t_rope_out;

    // One rotation stage: valid travels with the vector and residual angle
    typedef struct packed {
        logic                 valid;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_rot;

    typedef logic [PAIR_COUNT-1:0][FREQ_FRAC-1:0] t_freq_tab;
    typedef logic [CORDIC_STEPS-1:0][PHASE_W-1:0] t_atan_tab;

    // (a*b) >> s over the full 128-bit product
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int unsigned s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    // Restoring unsigned divide, elaboration only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // log2(ROPE_BASE) in Q.40 by repeated squaring
    function automatic logic [63:0] log2_base();
        logic [63:0] b;
        logic [63:0] m;
        logic [63:0] frac;
        int          n;
        int          k;
        b = 64'(ROPE_BASE);
        n = 0;
        frac = '0;
        while ((b >> (n + 1)) != 64'd0) n++;
        m = b << (61 - n);
        for (k = 1; k <= LOG_FRAC; k++) begin
            m = mul_shift(m, m, 61);
            if (m >= 64'h4000_0000_0000_0000) begin
                m = m >> 1;
                frac[LOG_FRAC-k] = 1'b1;
            end
        end
        return (64'(n) << LOG_FRAC) | frac;
    endfunction

    // Inverse frequency of pair i, in turns, Q0.44
    function automatic logic [FREQ_FRAC-1:0] freq_of(input logic [63:0] lg, input int i);
        logic [63:0] x;
        logic [63:0] q;
        logic [63:0] e;
        logic [63:0] y;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] v;
        logic [63:0] s;
        logic [63:0] res;
        logic        done;
        int          k;
        x    = (lg * 64'(2 * i)) / 64'(HEAD_LEN);
        q    = x >> LOG_FRAC;
        e    = (64'd1 << LOG_FRAC) - (x & ((64'd1 << LOG_FRAC) - 64'd1));
        y    = mul_shift(e, LN2_Q64, LOG_FRAC + 2);
        sum  = 64'd1 << 62;
        term = 64'd1 << 62;
        done = 1'b0;
        for (k = 1; k <= 40; k++) begin
            if (!done) begin
                term = div_u64(mul_shift(term, y, 62), 64'(k));
                if (term == 64'd0) done = 1'b1;
                else sum = sum + term;
            end
        end
        v = mul_shift(sum, INV_TWO_PI_Q64, 64);
        s = 64'(62 - FREQ_FRAC) + q + 64'd1;
        if (s >= 64'd62) res = '0;
        else res = (v + (64'd1 << (s - 64'd1))) >> s;
        return res[FREQ_FRAC-1:0];
    endfunction

    // arctan(2^-k) in 2^-32 turn units
    function automatic logic [PHASE_W-1:0] atan_of(input int k);
        logic [63:0] rad;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] v;
        logic [63:0] res;
        logic        done;
        int          n;
        rad  = '0;
        done = 1'b0;
        if (k == 0) begin
            res = 64'd1 << 29;
        end else begin
            for (n = 0; n < 64; n++) begin
                e = 64'(k) * 64'(2 * n + 1);
                if (e > 64'd62) done = 1'b1;
                if (!done) begin
                    t = div_u64(64'd1 << (64'd62 - e), 64'(2 * n + 1));
                    if (n % 2 == 1) rad = rad - t;
                    else rad = rad + t;
                end
            end
            v   = mul_shift(rad, INV_TWO_PI_Q64, 64);
            res = (v + (64'd1 << 29)) >> 30;
        end
        return res[PHASE_W-1:0];
    endfunction

    function automatic t_freq_tab build_freq_tab();
        t_freq_tab   tab;
        logic [63:0] lg;
        int          i;
        lg = log2_base();
        for (i = 0; i < PAIR_COUNT; i++) tab[i] = freq_of(lg, i);
        return tab;
    endfunction

    function automatic t_atan_tab build_atan_tab();
        t_atan_tab tab;
        int        i;
        for (i = 0; i < CORDIC_STEPS; i++) tab[i] = atan_of(i);
        return tab;
    endfunction

    localparam t_freq_tab FREQ_TAB = build_freq_tab();
    localparam t_atan_tab ATAN_TAB = build_atan_tab();

endpackage

`default_nettype wire

@@ design/rotary_position_embedding_unit.sv @@
// Path from input transfer to output valid: 3 phase stages, one register per CORDIC
//   micro-rotation, 28 of them, and the output register.
// Throughput: one pair per cycle while the skid slot is empty; all stages advance together and stall while it is full.
// A two-entry output register and skid slot hold results while the consumer stalls.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears start_position to 0.
`default_nettype none

module rotary_position_embedding_unit import rope_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // config write
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [POS_W-1:0] i_cfg_data,
    // input pairs
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_rope_in         i_in_data,
    // rotated pairs
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_rope_out             o_out_data
);

    // start_position register, always writable
    logic [POS_W-1:0] r_start_position;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_position <= '0;
        end else if (i_cfg_valid) begin
            r_start_position <= i_cfg_data;
        end
    end

    logic w_en;
    t_rot w_chain [CORDIC_STEPS+1];

    assign o_in_ready = w_en;

    rope_phase u_phase (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_valid          (i_in_valid),
        .i_data           (i_in_data),
        .i_start_position (r_start_position),
        .o_stage          (w_chain[0])
    );

    // CORDIC micro-rotation chain
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        rope_cordic_step #(
            .STEP (k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_chain[k]),
            .o_stage (w_chain[k+1])
        );
    end

    rope_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_chain[CORDIC_STEPS]),
        .o_en    (w_en),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ design/rope_phase.sv @@
`default_nettype none

module rope_phase import rope_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_rope_in         i_data,
    input  wire logic [POS_W-1:0] i_start_position,
    output t_rot                  o_stage
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Stage 1: absolute position and frequency lookup
    logic                       r_s1_valid;
    logic [POS_W:0]             r_s1_pos;
    logic [FREQ_FRAC-1:0]       r_s1_freq;
    logic signed [SAMPLE_W-1:0] r_s1_first;
    logic signed [SAMPLE_W-1:0] r_s1_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_pos    <= {1'b0, i_data.token_offset} + {1'b0, i_start_position};
            r_s1_freq   <= FREQ_TAB[i_data.pair_index];
            r_s1_first  <= i_data.first_value;
            r_s1_second <= i_data.second_value;
        end
    end

    // Stage 2: phase product, inverse-gain prescale
    localparam int PW = POS_W + 1 + FREQ_FRAC;
    localparam int GW = SAMPLE_W + 31;

    logic [PW-1:0]        w_prod;
    logic signed [GW-1:0] w_gx;
    logic signed [GW-1:0] w_gy;

    assign w_prod = PW'(r_s1_pos) * PW'(r_s1_freq);
    assign w_gx   = GW'(r_s1_first) * GW'(INV_GAIN_Q30);
    assign w_gy   = GW'(r_s1_second) * GW'(INV_GAIN_Q30);

    logic                 r_s2_valid;
    logic [FREQ_FRAC-1:0] r_s2_ph44;
    logic signed [31:0]   r_s2_x;
    logic signed [31:0]   r_s2_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // floor shift by 30 - GUARD_BITS
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_ph44 <= w_prod[FREQ_FRAC-1:0];
            r_s2_x    <= $signed(w_gx[30-GUARD_BITS+31:30-GUARD_BITS]);
            r_s2_y    <= $signed(w_gy[30-GUARD_BITS+31:30-GUARD_BITS]);
        end
    end

    // Stage 3: round phase to 32 bits, take out the quadrant exactly
    logic [FREQ_FRAC:0]    w_ph_sum;
    logic [PHASE_W-1:0]    w_ph;
    logic [PHASE_W-1:0]    w_qsum;
    logic [1:0]            w_quad;
    logic [PHASE_W-1:0]    w_rem;
    logic signed [XW-1:0]  w_xe;
    logic signed [XW-1:0]  w_ye;
    logic signed [XW-1:0]  w_xq;
    logic signed [XW-1:0]  w_yq;

    assign w_ph_sum = {1'b0, r_s2_ph44} + (FREQ_FRAC+1)'(1 << (FREQ_FRAC - 33));
    assign w_ph     = w_ph_sum[FREQ_FRAC-1:FREQ_FRAC-32];
    assign w_qsum   = w_ph + 32'h2000_0000;
    assign w_quad   = w_qsum[31:30];
    assign w_rem    = w_ph - {w_quad, 30'd0};
    assign w_xe     = XW'(r_s2_x);
    assign w_ye     = XW'(r_s2_y);

    always_comb begin
        w_xq = w_xe;
        w_yq = w_ye;
        case (w_quad)
            QUAD_0: begin
                w_xq = w_xe;
                w_yq = w_ye;
            end
            QUAD_1: begin
                w_xq = -w_ye;
                w_yq = w_xe;
            end
            QUAD_2: begin
                w_xq = -w_xe;
                w_yq = -w_ye;
            end
            QUAD_3: begin
                w_xq = w_ye;
                w_yq = -w_xe;
            end
            default: ;
        endcase
    end

    logic                 r_s3_valid;
    logic signed [XW-1:0] r_s3_x;
    logic signed [XW-1:0] r_s3_y;
    logic signed [ZW-1:0] r_s3_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_x <= w_xq;
            r_s3_y <= w_yq;
            r_s3_z <= ZW'($signed(w_rem));
        end
    end

    assign o_stage = '{valid: r_s3_valid, x: r_s3_x, y: r_s3_y, z: r_s3_z};

endmodule

`default_nettype wire

@@ design/rope_cordic_step.sv @@
`default_nettype none

module rope_cordic_step import rope_pkg::*; #(
    parameter int STEP = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire t_rot i_stage,
    output t_rot      o_stage
);

    localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TAB[STEP]);

    // One micro-rotation toward zero residual angle
    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic signed [XW-1:0] w_x;
    logic signed [XW-1:0] w_y;
    logic signed [ZW-1:0] w_z;

    assign w_dx = i_stage.y >>> STEP;
    assign w_dy = i_stage.x >>> STEP;

    always_comb begin
        if (!i_stage.z[ZW-1]) begin
            w_x = i_stage.x - w_dx;
            w_y = i_stage.y + w_dy;
            w_z = i_stage.z - ATAN;
        end else begin
            w_x = i_stage.x + w_dx;
            w_y = i_stage.y - w_dy;
            w_z = i_stage.z + ATAN;
        end
    end

    logic                 r_valid;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= w_x;
            r_y <= w_y;
            r_z <= w_z;
        end
    end

    assign o_stage = '{valid: r_valid, x: r_x, y: r_y, z: r_z};

endmodule

`default_nettype wire

@@ design/rope_out.sv @@
`default_nettype none

module rope_out import rope_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_rot i_stage,
    output logic      o_en,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_rope_out o_data
);

    // Round half up, drop guard bits, saturate
    function automatic logic signed [SAMPLE_W-1:0] finish(input logic signed [XW-1:0] v);
        logic signed [XW:0]          sum;
        logic signed [XW-GUARD_BITS:0] sh;
        logic [SAMPLE_W-1:0]         res;
        sum = (XW+1)'(v) + (XW+1)'(1 << (GUARD_BITS - 1));
        sh  = sum[XW:GUARD_BITS];
        if (sh[XW-GUARD_BITS:SAMPLE_W-1] == '0 || sh[XW-GUARD_BITS:SAMPLE_W-1] == '1) begin
            res = sh[SAMPLE_W-1:0];
        end else if (sh[XW-GUARD_BITS]) begin
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return $signed(res);
    endfunction

    t_rope_out w_result;
    logic      w_push;

    assign w_result.rotated_first  = finish(i_stage.x);
    assign w_result.rotated_second = finish(i_stage.y);

    // Pipeline advances while the skid slot is free
    logic      r_out_valid;
    logic      r_skid_valid;
    t_rope_out r_out_data;
    t_rope_out r_skid_data;

    assign o_en   = !r_skid_valid;
    assign w_push = i_stage.valid && o_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out_data <= r_skid_valid ? r_skid_data : w_result;
        end else if (w_push) begin
            r_skid_data <= w_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // Skid slot only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without output entry");

    // A result arriving at a stalled output must land in the skid slot
    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && w_push) |=> r_skid_valid)
        else $error("result lost at stalled output");

    // A taken output refills from the skid slot
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output");

endmodule

`default_nettype wire

@@ dv/rope_checker.sv @@
`timescale 1ns / 1ps

module rope_checker import rope_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    input  wire logic             i_cfg_ready,
    input  wire logic [POS_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire t_rope_in         i_in_data,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire t_rope_out        i_out_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    // Build-time constants of the rotation
    localparam int          HEAD_SIZE     = 128;
    localparam int          ROTARY_BASE   = 10000;
    localparam int          LOG_BITS      = 40;
    localparam int          RATE_BITS     = 44;
    localparam int          PAIR_SLOTS    = 64;
    localparam int          ANGLE_STEPS   = 28;
    localparam int          EXTRA_BITS    = 16;
    localparam longint      GAIN_COMP_Q30 = 64'sd652032874;
    localparam logic [63:0] TURN_PER_RAD  = 64'h28BE60DB9391054A;
    localparam logic [63:0] LN2_FRAC64    = 64'hB17217F7D1CF79AC;

    logic [RATE_BITS-1:0] turn_rate [PAIR_SLOTS];
    logic [31:0]          micro_rot [ANGLE_STEPS];
    logic [POS_W-1:0]     base_position;
    t_rope_out            expected_rot [$];
    int                   mismatches;

    // Upper part of a 64x64 product: (a*b) >> s
    function automatic logic [63:0] wide_mul_shr(input logic [63:0] a, input logic [63:0] b,
                                                 input int s);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod >> s;
        return prod[63:0];
    endfunction

    // log2 of the base, Q.40, one fraction bit per squaring
    function automatic logic [63:0] base_log2_q40();
        logic [63:0] mant;
        logic [63:0] frac_bits;
        int          whole;
        int          k;
        whole     = $clog2(ROTARY_BASE + 1) - 1;
        mant      = 64'(ROTARY_BASE) << (61 - whole);
        frac_bits = '0;
        for (k = 1; k <= LOG_BITS; k++) begin
            mant = wide_mul_shr(mant, mant, 61);
            if (mant >= (64'd1 << 62)) begin
                mant = mant >> 1;
                frac_bits[LOG_BITS-k] = 1'b1;
            end
        end
        return (64'(whole) << LOG_BITS) | frac_bits;
    endfunction

    // Turns per position for one pair: base^(-2i/head) / 2pi, Q0.44
    function automatic logic [RATE_BITS-1:0] pair_turn_rate(input logic [63:0] lg,
                                                            input int pair);
        logic [63:0] expo;
        logic [63:0] whole;
        logic [63:0] frac_left;
        logic [63:0] lny;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] scaled;
        logic [63:0] sh;
        int          k;
        expo      = lg * 64'(2 * pair) / 64'(HEAD_SIZE);
        whole     = expo >> LOG_BITS;
        frac_left = (64'd1 << LOG_BITS) - (expo & ((64'd1 << LOG_BITS) - 64'd1));
        lny       = wide_mul_shr(frac_left, LN2_FRAC64, LOG_BITS + 2);
        // e^lny by series, Q2.62, truncated terms
        acc  = 64'd1 << 62;
        term = 64'd1 << 62;
        for (k = 1; k <= 40 && term != 64'd0; k++) begin
            term = wide_mul_shr(term, lny, 62) / 64'(k);
            acc  = acc + term;
        end
        scaled = wide_mul_shr(acc, TURN_PER_RAD, 64);
        sh     = 64'(62 - RATE_BITS) + whole + 64'd1;
        if (sh >= 64'd62) return '0;
        return RATE_BITS'((scaled + (64'd1 << (sh - 64'd1))) >> sh);
    endfunction

    // atan(2^-k) in 2^-32 turn units
    function automatic logic [31:0] micro_angle(input int k);
        logic [63:0] rad;
        logic [63:0] t;
        int          n;
        if (k == 0) return 32'd1 << 29;
        rad = '0;
        for (n = 0; k * (2 * n + 1) <= 62; n++) begin
            t = (64'd1 << (62 - k * (2 * n + 1))) / 64'(2 * n + 1);
            if (n % 2 == 1) rad = rad - t;
            else rad = rad + t;
        end
        return 32'((wide_mul_shr(rad, TURN_PER_RAD, 64) + (64'd1 << 29)) >> 30);
    endfunction

    // Round off the guard bits, then clamp to the sample range
    function automatic logic signed [SAMPLE_W-1:0] round_clamp(input longint v);
        longint r;
        r = (v + (longint'(1) <<< (EXTRA_BITS - 1))) >>> EXTRA_BITS;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return SAMPLE_W'(r);
    endfunction

    // Expected rotated pair for one input transfer
    function automatic t_rope_out rotate_pair(input t_rope_in item,
                                              input logic [POS_W-1:0] start_pos);
        logic [POS_W:0]  position;
        logic [63:0]     phase44;
        logic [31:0]     phase;
        logic [31:0]     resid;
        logic [1:0]      quadrant;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          tmp;
        int              k;
        t_rope_out       res;
        position = (POS_W + 1)'(item.token_offset) + (POS_W + 1)'(start_pos);
        phase44  = (64'(position) * 64'(turn_rate[item.pair_index]))
                   & ((64'd1 << RATE_BITS) - 64'd1);
        phase    = 32'((phase44 + (64'd1 << (RATE_BITS - 33))) >> (RATE_BITS - 32));
        quadrant = 2'((64'(phase) + (64'd1 << 29)) >> 30);
        resid    = phase - {quadrant, 30'd0};
        z        = longint'($signed(resid));
        x = (longint'($signed(item.first_value)) * GAIN_COMP_Q30) >>> (30 - EXTRA_BITS);
        y = (longint'($signed(item.second_value)) * GAIN_COMP_Q30) >>> (30 - EXTRA_BITS);
        // exact quarter turns first
        case (quadrant)
            2'd1: begin
                tmp = x;
                x   = -y;
                y   = tmp;
            end
            2'd2: begin
                x = -x;
                y = -y;
            end
            2'd3: begin
                tmp = x;
                x   = y;
                y   = -tmp;
            end
            default: ;
        endcase
        for (k = 0; k < ANGLE_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'({32'd0, micro_rot[k]});
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'({32'd0, micro_rot[k]});
            end
        end
        res.rotated_first  = round_clamp(x);
        res.rotated_second = round_clamp(y);
        return res;
    endfunction

    initial begin : build_tables
        logic [63:0] lg;
        int          i;
        lg = base_log2_q40();
        for (i = 0; i < PAIR_SLOTS; i++) turn_rate[i] = pair_turn_rate(lg, i);
        for (i = 0; i < ANGLE_STEPS; i++) micro_rot[i] = micro_angle(i);
        mismatches    = 0;
        base_position = '0;
    end

    // Track config, predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_rope_out want;
        if (!i_rst_n) begin
            base_position = '0;
            expected_rot.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) base_position = i_cfg_data;
            if (i_in_valid && i_in_ready)
                expected_rot.push_back(rotate_pair(i_in_data, base_position));
            if (i_out_valid && i_out_ready) begin
                if (expected_rot.size() == 0) begin
                    $display("%0t: unexpected output transfer (%0d, %0d)", $time,
                             i_out_data.rotated_first, i_out_data.rotated_second);
                    mismatches++;
                end else begin
                    want = expected_rot.pop_front();
                    if (i_out_data.rotated_first !== want.rotated_first) begin
                        $display("%0t: rotated_first expected %0d, got %0d", $time,
                                 want.rotated_first, i_out_data.rotated_first);
                        mismatches++;
                    end
                    if (i_out_data.rotated_second !== want.rotated_second) begin
                        $display("%0t: rotated_second expected %0d, got %0d", $time,
                                 want.rotated_second, i_out_data.rotated_second);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= expected_rot.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench import rope_pkg::*;;

    localparam int RESET_CYCLES   = 10;
    localparam int PIPE_LATENCY   = 32;
    localparam int SETTLE_CYCLES  = 2 * PIPE_LATENCY;
    localparam int STALL_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 165;
    localparam int PHASE_COUNT    = 6;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [POS_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    t_rope_in         in_data = '0;
    logic             out_ready = 1'b0;
    wire logic        cfg_ready;
    wire logic        in_ready;
    wire logic        out_valid;
    t_rope_out        out_data;
    int               fail_count;
    int               pending_pairs;
    int               quiet_cycles = 0;
    bit               idle_enabled = 1'b1;
    bit               stall_request = 1'b0;

    always #6 clk = ~clk;

    rotary_position_embedding_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    rope_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_pairs)
    );

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(idle_enabled && $urandom_range(99) < 10);
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SAMPLE_W'(int'($urandom_range(63)) - 32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic t_rope_in random_pair();
        t_rope_in p;
        p.first_value  = pick_sample();
        p.second_value = pick_sample();
        if ($urandom_range(9) == 0) p.pair_index = $urandom_range(1) ? '1 : '0;
        else p.pair_index = PAIR_IDX_W'($urandom);
        case ($urandom_range(5))
            0: p.token_offset = POS_W'($urandom_range(15));
            1: p.token_offset = $urandom_range(1) ? '1 : '0;
            default: p.token_offset = POS_W'($urandom);
        endcase
        return p;
    endfunction

    function automatic t_rope_in make_pair(input int a, input int b, input int idx,
                                           input int tok);
        t_rope_in p;
        p.first_value  = SAMPLE_W'(a);
        p.second_value = SAMPLE_W'(b);
        p.pair_index   = PAIR_IDX_W'(idx);
        p.token_offset = POS_W'(tok);
        return p;
    endfunction

    // One input transfer, with random idle cycles ahead of it
    task automatic send_pair(input t_rope_in pair);
        while (idle_enabled && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pair;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop offering and wait until every expected pair has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_pairs != 0);
    endtask

    task automatic write_start(input logic [POS_W-1:0] value);
        wait_drained();
        repeat (PIPE_LATENCY) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [POS_W-1:0] phase_start [PHASE_COUNT];
        int               ph;
        int               n;
        int               tok;
        phase_start[0] = '0;
        phase_start[1] = 16'd1;
        phase_start[2] = '1;
        phase_start[3] = POS_W'($urandom);
        phase_start[4] = 16'h8000;
        phase_start[5] = POS_W'($urandom);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero angle, saturation, sign extremes, quadrant sweep on pair 0
        write_start('0);
        send_pair(make_pair(0, 0, 0, 0));
        send_pair(make_pair(32767, 0, 0, 0));
        send_pair(make_pair(32767, 32767, 0, 39));
        send_pair(make_pair(-32768, -32768, 0, 39));
        send_pair(make_pair(-32768, 32767, 0, 5));
        for (tok = 1; tok <= 6; tok++) send_pair(make_pair(16384, -8192, 0, tok));
        send_pair(make_pair(12345, -23456, 63, 65535));
        send_pair(make_pair(-1, 1, 32, 1000));

        // Largest start: position sum goes past 16 bits without wrapping
        write_start('1);
        send_pair(make_pair(32767, -32768, 0, 65535));
        send_pair(make_pair(-32768, 32767, 63, 65535));
        send_pair(make_pair(20000, 20000, 17, 0));

        // Random phases, each under its own start position
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            write_start(phase_start[ph]);
            idle_enabled = (ph != 1);
            if (ph == 3) stall_request = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) send_pair(random_pair());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
